@@ design/ohr_pkg.sv @@
// ----------------------------------------------------------------------------
// ohr_pkg
// Shared types and codes for the overwriting history ring.
// ----------------------------------------------------------------------------
package ohr_pkg;

    localparam int unsigned FIELD_W = 32;
    localparam int unsigned IDX_W   = 6;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic [FIELD_W-1:0] id;
        logic [FIELD_W-1:0] address;
        logic [FIELD_W-1:0] length;
        logic [FIELD_W-1:0] value;
        logic [FIELD_W-1:0] stamp;
    } t_rec;

    typedef struct packed {
        logic we;
        logic re;
        logic ok;
    } t_step;

endpackage

@@ design/ohr_mem.sv @@
// ----------------------------------------------------------------------------
// ohr_mem
// Record store: one port, written or read once per cycle, registered read.
// ----------------------------------------------------------------------------
module ohr_mem #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic          i_re,
    input  logic [AW-1:0] i_addr,
    input  ohr_pkg::t_rec i_wdata,
    output ohr_pkg::t_rec o_rdata
);

    ohr_pkg::t_rec r_mem [DEPTH];
    ohr_pkg::t_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/ohr_ctrl.sv @@
// ----------------------------------------------------------------------------
// ohr_ctrl
// Write pointer and fill count; picks the slot and decides each word's status.
// ----------------------------------------------------------------------------
module ohr_ctrl #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic                      i_operation,
    input  logic [ohr_pkg::IDX_W-1:0] i_read_index,
    output logic [AW-1:0]             o_slot,
    output ohr_pkg::t_step            o_step,
    output logic [ohr_pkg::IDX_W-1:0] o_count_next
);

    localparam int unsigned WW = ((AW > ohr_pkg::IDX_W) ? AW : ohr_pkg::IDX_W) + 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [AW-1:0] r_next, n_next;
    logic [AW-1:0] r_count, n_count;
    logic          full;
    logic [WW-1:0] next_w, back_w, count_w;

    assign full    = (r_count == LAST);
    assign next_w  = WW'(r_next);
    assign back_w  = WW'(i_read_index) + WW'(1);
    assign count_w = WW'(n_count);

    always_comb begin
        n_next       = r_next;
        n_count      = r_count;
        o_step       = '0;
        o_slot       = r_next;
        if (i_accept) begin
            if (i_operation == ohr_pkg::OP_ADD) begin
                o_step.we = 1'b1;
                o_step.ok = 1'b1;
                n_next    = (r_next == LAST) ? '0 : r_next + AW'(1);
                if (!full) begin
                    n_count = r_count + AW'(1);
                end
            end else begin
                o_step.re = 1'b1;
                o_step.ok = (WW'(i_read_index) < WW'(r_count));
                if (next_w >= back_w) begin
                    o_slot = AW'(next_w - back_w);
                end else begin
                    o_slot = AW'(next_w + WW'(DEPTH) - back_w);
                end
            end
        end
    end

    assign o_count_next = count_w[ohr_pkg::IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next  <= '0;
            r_count <= '0;
        end else begin
            r_next  <= n_next;
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LAST)
        else $error("fill count beyond ring capacity");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_operation == ohr_pkg::OP_ADD && !full)
        |=> (r_count == $past(r_count) + AW'(1)))
        else $error("add did not grow fill count");

    a_read_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_operation == ohr_pkg::OP_READ)
        |=> ($stable(r_next) && $stable(r_count)))
        else $error("read moved ring state");
`endif

endmodule

@@ design/overwriting_history_ring_core.sv @@
// ----------------------------------------------------------------------------
// overwriting_history_ring_core
// Ring log of parameter-write records that drops the oldest when full.
// ----------------------------------------------------------------------------
// One word may be started in every cycle once busy has dropped. Busy stays
// high during reset and until the live flag is registered after reset is
// released. Its result appears on the output ports in the cycle after start
// is taken, flagged by o_valid for a single cycle. The delay comes from the
// registered read port of the record store. The receiver cannot stall
// the block: each result must be taken in the cycle it is shown. The ring
// holds DEPTH-1 records. An add always reports ok. A read reports ok only
// when the age is below the fill count; otherwise the record fields read as
// zero.
module overwriting_history_ring_core #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_operation,
    input  logic [ohr_pkg::FIELD_W-1:0] i_record_id,
    input  logic [ohr_pkg::FIELD_W-1:0] i_param_address,
    input  logic [ohr_pkg::FIELD_W-1:0] i_address_length,
    input  logic [ohr_pkg::FIELD_W-1:0] i_written_value,
    input  logic [ohr_pkg::FIELD_W-1:0] i_timestamp,
    input  logic [ohr_pkg::IDX_W-1:0]   i_read_index,
    output logic                        o_valid,
    output logic                        o_ok,
    output logic [ohr_pkg::FIELD_W-1:0] o_out_id,
    output logic [ohr_pkg::FIELD_W-1:0] o_out_address,
    output logic [ohr_pkg::FIELD_W-1:0] o_out_length,
    output logic [ohr_pkg::FIELD_W-1:0] o_out_value,
    output logic [ohr_pkg::FIELD_W-1:0] o_out_time,
    output logic [ohr_pkg::IDX_W-1:0]   o_entry_count
);

    localparam int unsigned AW = $clog2(DEPTH);

    logic                      accept;
    logic [AW-1:0]             slot;
    ohr_pkg::t_step            step;
    logic [ohr_pkg::IDX_W-1:0] count_next;
    ohr_pkg::t_rec             wdata, rdata;

    logic                      r_live;
    logic                      r_valid;
    logic                      r_ok;
    logic                      r_read;
    logic [ohr_pkg::IDX_W-1:0] r_count;

    assign busy   = !r_live;
    assign accept = start && !busy;

    assign wdata.id      = i_record_id;
    assign wdata.address = i_param_address;
    assign wdata.length  = i_address_length;
    assign wdata.value   = i_written_value;
    assign wdata.stamp   = i_timestamp;

    ohr_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_operation  (i_operation),
        .i_read_index (i_read_index),
        .o_slot       (slot),
        .o_step       (step),
        .o_count_next (count_next)
    );

    ohr_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (step.we),
        .i_re    (step.re),
        .i_addr  (slot),
        .i_wdata (wdata),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live  <= 1'b0;
            r_valid <= 1'b0;
            r_ok    <= 1'b0;
            r_read  <= 1'b0;
            r_count <= '0;
        end else begin
            r_live  <= 1'b1;
            r_valid <= accept;
            if (accept) begin
                r_ok    <= step.ok;
                r_read  <= step.re;
                r_count <= count_next;
            end
        end
    end

    logic show;
    assign show = r_read && r_ok;

    assign o_valid       = r_valid;
    assign o_ok          = r_ok;
    assign o_entry_count = r_count;
    assign o_out_id      = show ? rdata.id      : '0;
    assign o_out_address = show ? rdata.address : '0;
    assign o_out_length  = show ? rdata.length  : '0;
    assign o_out_value   = show ? rdata.value   : '0;
    assign o_out_time    = show ? rdata.stamp   : '0;

`ifndef SYNTHESIS
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("accepted word produced no result");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_out_id == '0 && o_out_time == '0))
        else $error("failed read carries record data");
`endif

endmodule

@@ tb/ohr_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// ohr_tb_pkg
// Checking side of the history ring bench. The scoreboard keeps its own
// ring of records, works out the reply to every word that is taken and
// compares each reply that comes out of the block with the oldest one due.
// ----------------------------------------------------------------------------
package ohr_tb_pkg;

    import ohr_pkg::*;

    localparam int unsigned RING_SLOTS = 64;
    localparam int unsigned MAX_HELD   = RING_SLOTS - 1;
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct packed {
        logic             ok;
        t_rec             rec;
        logic [IDX_W-1:0] count;
    } t_ring_reply;

    class ring_log_scoreboard;

        t_rec        log_slots [RING_SLOTS];
        int unsigned oldest_slot = 0;
        int unsigned next_slot   = 0;
        t_ring_reply replies_due [$];
        int unsigned mismatches  = 0;
        int unsigned reply_no    = 0;

        function int unsigned records_held();
            return (next_slot + RING_SLOTS - oldest_slot) % RING_SLOTS;
        endfunction

        function int unsigned pending();
            return replies_due.size();
        endfunction

        // Advance the private ring by one word and queue the reply it causes.
        function void note_word(logic op, t_rec rec_in, logic [IDX_W-1:0] age);
            t_ring_reply want;
            int unsigned slot;
            want = '0;
            if (op == OP_ADD) begin
                if ((next_slot + 1) % RING_SLOTS == oldest_slot) begin
                    oldest_slot = (oldest_slot + 1) % RING_SLOTS;
                end
                log_slots[next_slot] = rec_in;
                next_slot = (next_slot + 1) % RING_SLOTS;
                want.ok = 1'b1;
            end else if (age < records_held()) begin
                slot = (next_slot + RING_SLOTS - age - 1) % RING_SLOTS;
                want.rec = log_slots[slot];
                want.ok  = 1'b1;
            end
            want.count = IDX_W'(records_held());
            replies_due.push_back(want);
        endfunction

        function void check_reply(t_ring_reply got);
            t_ring_reply want;
            reply_no++;
            if (replies_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("reply %0d: nothing pending, got ok=%b id=%h cnt=%0d",
                             reply_no, got.ok, got.rec.id, got.count);
                end
                return;
            end
            want = replies_due.pop_front();
            if (got.ok !== want.ok || got.rec.id !== want.rec.id ||
                got.rec.address !== want.rec.address ||
                got.rec.length !== want.rec.length ||
                got.rec.value !== want.rec.value ||
                got.rec.stamp !== want.rec.stamp || got.count !== want.count) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("reply %0d exp: ok=%b id=%h addr=%h len=%h val=%h time=%h cnt=%0d",
                             reply_no, want.ok, want.rec.id, want.rec.address,
                             want.rec.length, want.rec.value, want.rec.stamp, want.count);
                    $display("reply %0d got: ok=%b id=%h addr=%h len=%h val=%h time=%h cnt=%0d",
                             reply_no, got.ok, got.rec.id, got.rec.address,
                             got.rec.length, got.rec.value, got.rec.stamp, got.count);
                end
            end
        endfunction

    endclass

endpackage

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Bench for the overwriting history ring. A directed run covers empty,
// boundary and extreme-value words; a random run then fills and overflows
// the ring with bursty adds and reads of every age, checking each reply.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import ohr_pkg::*;
    import ohr_tb_pkg::*;

    localparam int unsigned WORD_TARGET = 1550;
    localparam int unsigned QUIET_LIMIT = 1000;

    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               start            = 1'b0;
    logic               busy;
    logic               i_operation      = OP_ADD;
    logic [FIELD_W-1:0] i_record_id      = '0;
    logic [FIELD_W-1:0] i_param_address  = '0;
    logic [FIELD_W-1:0] i_address_length = '0;
    logic [FIELD_W-1:0] i_written_value  = '0;
    logic [FIELD_W-1:0] i_timestamp      = '0;
    logic [IDX_W-1:0]   i_read_index     = '0;
    logic               o_valid;
    logic               o_ok;
    logic [FIELD_W-1:0] o_out_id;
    logic [FIELD_W-1:0] o_out_address;
    logic [FIELD_W-1:0] o_out_length;
    logic [FIELD_W-1:0] o_out_value;
    logic [FIELD_W-1:0] o_out_time;
    logic [IDX_W-1:0]   o_entry_count;

    ring_log_scoreboard sb;
    int unsigned        words_sent  = 0;
    int unsigned        fill_guess  = 0;
    int unsigned        burst_left  = 1;
    int unsigned        quiet_count = 0;

    overwriting_history_ring_core #(
        .DEPTH(RING_SLOTS)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_operation      (i_operation),
        .i_record_id      (i_record_id),
        .i_param_address  (i_param_address),
        .i_address_length (i_address_length),
        .i_written_value  (i_written_value),
        .i_timestamp      (i_timestamp),
        .i_read_index     (i_read_index),
        .o_valid          (o_valid),
        .o_ok             (o_ok),
        .o_out_id         (o_out_id),
        .o_out_address    (o_out_address),
        .o_out_length     (o_out_length),
        .o_out_value      (o_out_value),
        .o_out_time       (o_out_time),
        .o_entry_count    (o_entry_count)
    );

    always #1 i_clk = ~i_clk;

    // Words taken and replies seen are both sampled here, word first.
    always @(posedge i_clk) begin
        t_rec        taken;
        t_ring_reply seen;
        if (i_rst_n && start && !busy) begin
            taken.id      = i_record_id;
            taken.address = i_param_address;
            taken.length  = i_address_length;
            taken.value   = i_written_value;
            taken.stamp   = i_timestamp;
            sb.note_word(i_operation, taken, i_read_index);
        end
        if (i_rst_n && o_valid) begin
            seen.ok          = o_ok;
            seen.rec.id      = o_out_id;
            seen.rec.address = o_out_address;
            seen.rec.length  = o_out_length;
            seen.rec.value   = o_out_value;
            seen.rec.stamp   = o_out_time;
            seen.count       = o_entry_count;
            sb.check_reply(seen);
        end
        if ((start && !busy) || o_valid) begin
            quiet_count = 0;
        end else begin
            quiet_count++;
        end
        if (quiet_count >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [FIELD_W-1:0] pick_field();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_rec pick_rec();
        t_rec r;
        r.id      = pick_field();
        r.address = pick_field();
        r.length  = pick_field();
        r.value   = pick_field();
        r.stamp   = pick_field();
        return r;
    endfunction

    // Ages cluster round the fill level so both sides of the bound get hit.
    function automatic logic [IDX_W-1:0] pick_age(int unsigned held);
        case ($urandom_range(0, 6))
            0: return '0;
            1: return (held == 0) ? '0 : IDX_W'(held - 1);
            2: return IDX_W'(held);
            3: return (held >= MAX_HELD) ? '1 : IDX_W'(held + 1);
            4: return '1;
            default: return IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
        endcase
    endfunction

    task automatic idle_for(int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic put_word(logic op, t_rec rec, logic [IDX_W-1:0] age);
        start            <= 1'b1;
        i_operation      <= op;
        i_record_id      <= rec.id;
        i_param_address  <= rec.address;
        i_address_length <= rec.length;
        i_written_value  <= rec.value;
        i_timestamp      <= rec.stamp;
        i_read_index     <= age;
        do @(posedge i_clk); while (busy);
        words_sent++;
        if (op == OP_ADD && fill_guess < MAX_HELD) begin
            fill_guess++;
        end
        burst_left--;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 20);
            idle_for($urandom_range(1, 5));
        end
    endtask

    task automatic add_rec(t_rec rec);
        put_word(OP_ADD, rec, pick_age(fill_guess));
    endtask

    task automatic read_age(logic [IDX_W-1:0] age);
        put_word(OP_READ, pick_rec(), age);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        int unsigned mode;
        int unsigned run;
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty ring, extremes, age bounds
        read_age('0);
        read_age('1);
        add_rec('0);
        add_rec('1);
        read_age(6'd0);
        read_age(6'd1);
        read_age(6'd2);
        read_age('1);
        add_rec({5{32'hAAAA_AAAA}});
        add_rec({5{32'h5555_5555}});
        add_rec('{id: 32'h1, address: 32'h8000_0000, length: 32'h7FFF_FFFF,
                  value: 32'hFFFF_FFFE, stamp: 32'h0000_0001});
        read_age(6'd4);
        read_age(6'd5);
        read_age(6'd2);
        put_word(OP_READ, '1, 6'd0);
        drain();

        while (words_sent < WORD_TARGET) begin
            mode = $urandom_range(0, 9);
            if (mode < 4) begin
                run = (mode == 0 && $urandom_range(0, 3) == 0) ? $urandom_range(60, 80)
                                                                : $urandom_range(1, 4);
                repeat (run) add_rec(pick_rec());
            end else if (mode < 8) begin
                run = $urandom_range(1, 8);
                repeat (run) read_age(pick_age(fill_guess));
            end else begin
                run = $urandom_range(1, 10);
                repeat (run) begin
                    if ($urandom_range(0, 1) == 0) begin
                        add_rec(pick_rec());
                    end else begin
                        read_age(pick_age(fill_guess));
                    end
                end
            end
            if ($urandom_range(0, 39) == 0) begin
                drain();
            end
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
